// ===== rtl/kdlp_pkg.sv =====
`default_nettype none

package kdlp_pkg;

    localparam int KDLP_SCAN_BITS = 16;
    localparam int KDLP_KEY_W     = 4;
    localparam int KDLP_THR_W     = 8;
    localparam int KDLP_ROWS      = 4;
    localparam int KDLP_COLS      = 4;

    localparam logic [KDLP_THR_W-1:0] KDLP_THR_RESET = 8'd20;
    localparam logic [KDLP_THR_W-1:0] KDLP_THR_LIMIT = 8'd254;

    typedef enum logic [1:0] {
        EVT_SHORT        = 2'd0,
        EVT_LONG         = 2'd1,
        EVT_LONG_RELEASE = 2'd2
    } evt_kind_t;

    typedef struct packed {
        logic [KDLP_SCAN_BITS-1:0] scan_first;
        logic [KDLP_SCAN_BITS-1:0] scan_second;
    } poll_t;

    typedef struct packed {
        logic [KDLP_KEY_W-1:0] key_index;
        logic [1:0]            event_kind;
        logic [5:0]            event_code;
    } evt_t;

    // what one row lane, or the merged decode of a snapshot, reports
    typedef struct packed {
        logic                  hit;
        logic [KDLP_KEY_W-1:0] key;
    } kdlp_hit_t;

endpackage

`default_nettype wire

// ===== rtl/kdlp_row_lane.sv =====
`default_nettype none

module kdlp_row_lane #(
    parameter int COLS = kdlp_pkg::KDLP_COLS,
    parameter int ROW  = 0
) (
    input  wire logic [kdlp_pkg::KDLP_SCAN_BITS-1:0] snap,
    output kdlp_pkg::kdlp_hit_t                      lane
);
    import kdlp_pkg::*;

    localparam int BASE = ROW * COLS;

    logic [COLS-1:0] pressed;

    // lines past the snapshot width read as released
    for (genvar c = 0; c < COLS; c++) begin : g_col
        if (BASE + c < KDLP_SCAN_BITS) begin : g_in
            assign pressed[c] = ~snap[BASE + c];
        end
        else begin : g_out
            assign pressed[c] = 1'b0;
        end
    end

    always_comb
    begin
        lane.hit = (pressed != '0) && ((pressed & (pressed - 1'b1)) == '0);
        lane.key = '0;
        for (int c = 0; c < COLS; c++)
        begin
            if (pressed[c])
            begin
                lane.key = KDLP_KEY_W'(BASE + c);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kdlp_matrix_decode.sv =====
`default_nettype none

module kdlp_matrix_decode #(
    parameter int ROWS = kdlp_pkg::KDLP_ROWS,
    parameter int COLS = kdlp_pkg::KDLP_COLS
) (
    input  wire logic [kdlp_pkg::KDLP_SCAN_BITS-1:0] snap,
    output kdlp_pkg::kdlp_hit_t                      dec
);
    import kdlp_pkg::*;

    kdlp_hit_t lanes [ROWS];

    for (genvar r = 0; r < ROWS; r++) begin : g_row
        kdlp_row_lane #(
            .COLS (COLS),
            .ROW  (r)
        ) u_lane (
            .snap (snap),
            .lane (lanes[r])
        );
    end

    // lowest row with a single pressed line wins
    always_comb
    begin
        dec = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (lanes[r].hit)
            begin
                dec = lanes[r];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keypad_debounce_long_press.sv =====
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------------
// poll     | in        | poll_valid/poll_stall | scan_first, scan_second
// evt      | out       | evt_valid/evt_stall   | key_index, event_kind, event_code
// cfg      | in        | cfg_valid/cfg_ready   | long_press_ticks (cfg_data)
//
// one poll per cycle unless stalled; a poll's event, if any, shows on evt the next cycle
// unless evt is stalled, then it waits in the skid slot behind the output register
// both snapshots go through ROWS row lanes each in the transfer cycle, then the counter updates
// rst_n clears threshold to 20, hold counter, held key and both output slots
// output register plus one skid slot; poll_stall rises only while the skid slot is full
// cfg_ready is always high, the threshold is written in the same cycle

module keypad_debounce_long_press #(
    parameter int ROWS = kdlp_pkg::KDLP_ROWS,
    parameter int COLS = kdlp_pkg::KDLP_COLS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            poll_valid,
    output logic                                 poll_stall,
    input  wire kdlp_pkg::poll_t                 poll,

    output logic                                 evt_valid,
    input  wire logic                            evt_stall,
    output kdlp_pkg::evt_t                       evt,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kdlp_pkg::KDLP_THR_W-1:0] cfg_data
);
    import kdlp_pkg::*;

    // threshold register and its effective value (255 acts as 254)
    logic [KDLP_THR_W-1:0] thr_reg;
    logic [KDLP_THR_W-1:0] thr;
    logic [KDLP_THR_W-1:0] thr_plus1;

    // hold counter and latched key
    logic [KDLP_THR_W-1:0] hold_reg;
    logic [KDLP_THR_W-1:0] hold_next;
    logic [KDLP_KEY_W-1:0] held_reg;
    logic [KDLP_KEY_W-1:0] held_next;

    // output register and skid slot
    logic out_valid_reg;
    logic out_valid_next;
    evt_t out_reg;
    evt_t out_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    evt_t skid_reg;
    evt_t skid_next;

    logic      poll_xfer;
    logic      out_take;
    kdlp_hit_t dec_first;
    kdlp_hit_t dec_second;
    logic      res_valid;
    evt_kind_t res_kind;
    logic [KDLP_KEY_W-1:0] res_key;
    evt_t      res_evt;

    assign cfg_ready  = 1'b1;
    assign poll_stall = skid_valid_reg;
    assign poll_xfer  = poll_valid && !poll_stall;
    assign out_take   = out_valid_reg && !evt_stall;
    assign evt_valid  = out_valid_reg;
    assign evt        = out_reg;

    assign thr       = (thr_reg > KDLP_THR_LIMIT) ? KDLP_THR_LIMIT : thr_reg;
    assign thr_plus1 = thr + 1'b1;

    // both snapshots decoded side by side, each by its own set of row lanes
    kdlp_matrix_decode #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dec_first (
        .snap (poll.scan_first),
        .dec  (dec_first)
    );

    kdlp_matrix_decode #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dec_second (
        .snap (poll.scan_second),
        .dec  (dec_second)
    );

    // press / hold / release tracking
    always_comb
    begin
        hold_next = hold_reg;
        held_next = held_reg;
        res_valid = 1'b0;
        res_kind  = EVT_SHORT;
        res_key   = held_reg;
        if (poll_xfer)
        begin
            if (dec_first.hit)
            begin
                // a key counts only when both snapshots agree
                if (dec_second.hit && (dec_second.key == dec_first.key))
                begin
                    held_next = dec_first.key;
                    if (hold_reg < thr)
                    begin
                        hold_next = hold_reg + 1'b1;
                    end
                    else if (hold_reg == thr)
                    begin
                        hold_next = thr_plus1;
                        res_valid = 1'b1;
                        res_kind  = EVT_LONG;
                        res_key   = dec_first.key;
                    end
                end
            end
            else
            begin
                // release: second snapshot does not matter
                hold_next = '0;
                if ((hold_reg != '0) && (hold_reg < thr))
                begin
                    res_valid = 1'b1;
                    res_kind  = EVT_SHORT;
                end
                else if (hold_reg == thr_plus1)
                begin
                    res_valid = 1'b1;
                    res_kind  = EVT_LONG_RELEASE;
                end
            end
        end
    end

    always_comb
    begin
        res_evt.key_index  = res_key;
        res_evt.event_kind = res_kind;
        res_evt.event_code = {res_kind, res_key};
    end

    // output register with skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no poll transfer while the skid slot is full
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_next       = res_evt;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = res_evt;
                out_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= KDLP_THR_RESET;
            hold_reg       <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
            hold_reg       <= hold_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // skid slot is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with empty output register");

    // a release always clears the hold counter
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (poll_xfer && !dec_first.hit) |=> (hold_reg == '0))
        else $error("hold counter not cleared on release");

    // a long-press event leaves the counter one past the threshold
    a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_kind == EVT_LONG)) |=> (hold_reg == $past(thr_plus1)))
        else $error("hold counter wrong after long press");

    // the code shown always matches kind and key
    a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.event_code == {evt.event_kind, evt.key_index}))
        else $error("event code does not match kind and key");

    // a result is never dropped: none is produced while the skid slot is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !skid_valid_reg)
        else $error("result produced while skid slot full");

endmodule

`default_nettype wire
